/* rtl/etrb_pkg.sv */
// Shared constants, codes and the command record of the event trace ring buffer.
package etrb_pkg;

  // Default number of record slots in the ring.
  localparam int unsigned DEPTH_DEFAULT = 16;

  // Most records that one read drains; larger requests saturate here.
  localparam int unsigned MAX_DRAIN = 16;
  localparam int unsigned TAKE_W    = $clog2(MAX_DRAIN + 1);

  // Command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Input command codes.
  localparam logic [1:0] CMD_PUSH_EVENT = 2'd0;
  localparam logic [1:0] CMD_PUSH_FAULT = 2'd1;
  localparam logic [1:0] CMD_PUSH_TRACE = 2'd2;
  localparam logic [1:0] CMD_READ       = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_STORED   = 2'd0;
  localparam logic [1:0] KIND_DROPPED  = 2'd1;
  localparam logic [1:0] KIND_RETURNED = 2'd2;
  localparam logic [1:0] KIND_NONE     = 2'd3;

  // Classified command handed from front to back.
  typedef struct packed {
    logic              is_read;
    logic              is_fault;
    logic [1:0]        category;
    logic [15:0]       code;
    logic [7:0]        severity;
    logic [31:0]       detail;
    logic [31:0]       tick;
    logic [TAKE_W-1:0] max_read;
  } etrb_cmd_t;

endpackage

/* rtl/etrb_ifs.sv */
// Handshake channels of the event trace ring buffer: command in, result out.
interface etrb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] code;
  logic [7:0]  severity;
  logic [31:0] detail;
  logic [31:0] tick;
  logic [4:0]  max_read;

  modport source (output valid, cmd, code, severity, detail, tick, max_read, input ready);
  modport sink   (input valid, cmd, code, severity, detail, tick, max_read, output ready);
endinterface

interface etrb_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] rec_code;
  logic [1:0]  rec_category;
  logic [7:0]  rec_severity;
  logic [31:0] rec_detail;
  logic [31:0] rec_tick;
  logic        last;
  logic [4:0]  occupancy;
  logic [31:0] dropped_count;
  logic [31:0] total_count;
  logic [31:0] fault_count;

  modport source (output valid, kind, rec_code, rec_category, rec_severity, rec_detail,
                  rec_tick, last, occupancy, dropped_count, total_count, fault_count,
                  input ready);
  modport sink   (input valid, kind, rec_code, rec_category, rec_severity, rec_detail,
                  rec_tick, last, occupancy, dropped_count, total_count, fault_count,
                  output ready);
endinterface

/* rtl/event_trace_ring_buffer_core.sv */
// Top level of the event trace ring buffer: front end, command queue and back end.
//
// Stores timestamped event, fault and trace records in a ring of DEPTH slots and
// drains them oldest first. Every command yields one or more results on the rsp_o
// channel; each carries the occupancy and the drop, total and fault counters as
// they stand after that result. Pushes flow through the back end at one transfer
// per clock once the result channel keeps up. A read that returns n records (n
// up to 16, limited by max_read and the fill) occupies the back end until its last
// record is out, one record per cycle while the result channel keeps up, paced by
// the single read port of the record memory; an empty read or a zero max_read gives
// a single no-record result. A two-entry command queue sits between the front and
// back ends, so commands keep arriving while a drain runs or a result waits. Record
// storage is not cleared at reset; only slots that have been pushed are ever read back.
module event_trace_ring_buffer_core import etrb_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  etrb_req_if.sink   req_i,
  etrb_rsp_if.source rsp_o
);

  logic      cmd_valid;
  logic      cmd_pop;
  etrb_cmd_t cmd;

  // Accept, classify and queue commands.
  etrb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Carry out pushes and drains, hold the result until transferred.
  etrb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .rsp_o       (rsp_o)
  );

endmodule

/* rtl/etrb_front.sv */
// Front end: classify incoming commands and hold them in a short queue.
module etrb_front import etrb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  etrb_req_if.sink   req_i,
  output logic       cmd_valid_o,
  output etrb_cmd_t  cmd_o,
  input  logic       cmd_pop_i
);

  localparam int unsigned QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QAW-1:0] QPTR_LAST = QAW'(QUEUE_DEPTH - 1);
  localparam logic [QCW-1:0] QFULL     = QCW'(QUEUE_DEPTH);

  etrb_cmd_t        q_mem [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0]   count_q, count_d;
  etrb_cmd_t        cls;
  logic             push, pop;

  // Classify: force severity to zero unless fault, saturate the drain request.
  always_comb begin
    cls          = '0;
    cls.code     = req_i.code;
    cls.detail   = req_i.detail;
    cls.tick     = req_i.tick;
    cls.category = req_i.cmd;
    cls.max_read = (req_i.max_read > TAKE_W'(MAX_DRAIN)) ? TAKE_W'(MAX_DRAIN)
                                                          : req_i.max_read;
    unique case (req_i.cmd)
      CMD_PUSH_FAULT: begin
        cls.is_fault = 1'b1;
        cls.severity = req_i.severity;
      end
      CMD_READ: begin
        cls.is_read = 1'b1;
      end
      default: begin
        cls.severity = '0;
      end
    endcase
  end

  assign req_i.ready = (count_q != QFULL);
  assign push        = req_i.valid && req_i.ready;
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_LAST) ? '0 : wr_ptr_q + QAW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_LAST) ? '0 : rd_ptr_q + QAW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + QCW'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

endmodule

/* rtl/etrb_back.sv */
// Back end: record ring, counters, drain sequencer and result register.
module etrb_back import etrb_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  etrb_cmd_t  cmd_i,
  output logic       cmd_pop_o,
  etrb_rsp_if.source rsp_o
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = $clog2(2 * DEPTH);
  localparam int unsigned CMP_W = (PW > TAKE_W) ? PW : TAKE_W;
  localparam logic [PW-1:0] PTR_LAST = PW'(2 * DEPTH - 1);
  localparam logic [PW-1:0] DEPTH_P  = PW'(DEPTH);
  localparam logic [PW:0]   RANGE_P  = (PW + 1)'(2 * DEPTH);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_slot(input logic [PW-1:0] p);
    return (p >= DEPTH_P) ? AW'(p - DEPTH_P) : AW'(p);
  endfunction

  logic [63:0]       pay_mem  [DEPTH];
  logic [25:0]       meta_mem [DEPTH];
  logic [63:0]       rd_pay_q;
  logic [25:0]       rd_meta_q;

  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [31:0]       drop_q, drop_d;
  logic [31:0]       push_q, push_d;
  logic [31:0]       fault_q, fault_d;
  logic              state_q, state_d;
  logic [TAKE_W-1:0] remain_q, remain_d;

  logic              out_valid_q, out_valid_d;
  logic [1:0]        kind_q, kind_d;
  logic              last_q, last_d;
  logic              rec_q, rec_d;

  logic [PW:0]       diff;
  logic [PW-1:0]     fill;
  logic              full;
  logic [CMP_W-1:0]  fill_x, maxr_x;
  logic [TAKE_W-1:0] take;
  logic              out_free, start, drain_step, issue_rd, push_ok, push_drop, load;

  // Occupancy from the two wrapping pointers.
  assign diff   = {1'b0, wr_ptr_q} + RANGE_P - {1'b0, rd_ptr_q};
  assign fill   = (diff >= RANGE_P) ? PW'(diff - RANGE_P) : PW'(diff);
  assign full   = (fill >= DEPTH_P);
  assign fill_x = CMP_W'(fill);
  assign maxr_x = CMP_W'(cmd_i.max_read);
  assign take   = (fill_x < maxr_x) ? TAKE_W'(fill_x) : TAKE_W'(maxr_x);

  assign out_free   = !out_valid_q || rsp_o.ready;
  assign start      = (state_q == ST_IDLE) && cmd_valid_i && out_free;
  assign drain_step = (state_q == ST_DRAIN) && out_free;
  assign issue_rd   = (start && cmd_i.is_read && (take != '0)) || drain_step;
  assign push_ok    = start && !cmd_i.is_read && !full;
  assign push_drop  = start && !cmd_i.is_read && full;
  assign load       = start || drain_step;
  assign cmd_pop_o  = start;

  always_comb begin
    wr_ptr_d    = push_ok  ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d    = issue_rd ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    drop_d      = push_drop ? drop_q + 32'd1 : drop_q;
    push_d      = (start && !cmd_i.is_read) ? push_q + 32'd1 : push_q;
    fault_d     = (start && !cmd_i.is_read && cmd_i.is_fault) ? fault_q + 32'd1 : fault_q;
    state_d     = state_q;
    remain_d    = remain_q;
    kind_d      = kind_q;
    last_d      = last_q;
    rec_d       = rec_q;
    out_valid_d = out_valid_q && !rsp_o.ready;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          rec_d = issue_rd;
          if (!cmd_i.is_read) begin
            kind_d = push_ok ? KIND_STORED : KIND_DROPPED;
            last_d = 1'b1;
          end else if (take == '0) begin
            kind_d = KIND_NONE;
            last_d = 1'b1;
          end else begin
            kind_d = KIND_RETURNED;
            last_d = (take < TAKE_W'(2));
            if (take >= TAKE_W'(2)) begin
              state_d  = ST_DRAIN;
              remain_d = take - TAKE_W'(1);
            end
          end
        end
      end
      ST_DRAIN: begin
        if (drain_step) begin
          rec_d    = 1'b1;
          kind_d   = KIND_RETURNED;
          last_d   = (remain_q == TAKE_W'(1));
          remain_d = remain_q - TAKE_W'(1);
          if (remain_q == TAKE_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      drop_q      <= '0;
      push_q      <= '0;
      fault_q     <= '0;
      state_q     <= ST_IDLE;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      drop_q      <= drop_d;
      push_q      <= push_d;
      fault_q     <= fault_d;
      state_q     <= state_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload flops: written only alongside a new result.
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    last_q <= last_d;
    rec_q  <= rec_d;
  end

  // Record ring: one write port for pushes, one registered read port for drains.
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      pay_mem[ptr_slot(wr_ptr_q)]  <= {cmd_i.tick, cmd_i.detail};
      meta_mem[ptr_slot(wr_ptr_q)] <= {cmd_i.category, cmd_i.severity, cmd_i.code};
    end
    if (issue_rd) begin
      rd_pay_q  <= pay_mem[ptr_slot(rd_ptr_q)];
      rd_meta_q <= meta_mem[ptr_slot(rd_ptr_q)];
    end
  end

  // Counters and pointers only move when a new result loads, so while a
  // result waits they still show the values that belong to it.
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.kind          = kind_q;
  assign rsp_o.last          = last_q;
  assign rsp_o.rec_code      = rec_q ? rd_meta_q[15:0]  : 16'd0;
  assign rsp_o.rec_severity  = rec_q ? rd_meta_q[23:16] : 8'd0;
  assign rsp_o.rec_category  = rec_q ? rd_meta_q[25:24] : 2'd0;
  assign rsp_o.rec_detail    = rec_q ? rd_pay_q[31:0]   : 32'd0;
  assign rsp_o.rec_tick      = rec_q ? rd_pay_q[63:32]  : 32'd0;
  assign rsp_o.occupancy     = 5'(fill);
  assign rsp_o.dropped_count = drop_q;
  assign rsp_o.total_count   = push_q;
  assign rsp_o.fault_count   = fault_q;

endmodule

/* tb/event_trace_ring_buffer_core_tb.sv */
// Self-checking testbench of the event trace ring buffer with a record-ring scoreboard.
module event_trace_ring_buffer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import etrb_pkg::*;

  localparam int unsigned RING_DEPTH        = DEPTH_DEFAULT;
  localparam int unsigned RANDOM_ITEMS      = 380;
  localparam int unsigned PRESSURE_AT       = 120;
  localparam int unsigned PRESSURE_ITEMS    = 40;
  localparam int unsigned HOLD_OFF_CYCLES   = 100;
  localparam int unsigned IDLE_LIMIT        = 1000;
  localparam int unsigned DRAIN_TAIL_CYCLES = 40;

  // One command as offered on the request channel.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] code;
    logic [7:0]  severity;
    logic [31:0] detail;
    logic [31:0] tick;
    logic [4:0]  max_read;
  } trace_cmd_t;

  // One record as held in the ring.
  typedef struct packed {
    logic [15:0] code;
    logic [1:0]  category;
    logic [7:0]  severity;
    logic [31:0] detail;
    logic [31:0] tick;
  } trace_record_t;

  // One result as seen on the response channel.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] rec_code;
    logic [1:0]  rec_category;
    logic [7:0]  rec_severity;
    logic [31:0] rec_detail;
    logic [31:0] rec_tick;
    logic        last;
    logic [4:0]  occupancy;
    logic [31:0] dropped_count;
    logic [31:0] total_count;
    logic [31:0] fault_count;
  } trace_result_t;

  // Shadow ring and counters; turns accepted commands into the results they must cause.
  class trace_scoreboard;
    trace_record_t ring [RING_DEPTH];
    int unsigned   head;
    int unsigned   tail;
    logic [31:0]   drops;
    logic [31:0]   pushes;
    logic [31:0]   faults;
    trace_result_t expected_q [$];
    int unsigned   errors;

    function new();
      head   = 0;
      tail   = 0;
      drops  = '0;
      pushes = '0;
      faults = '0;
      errors = 0;
    endfunction

    // Both indexes run modulo twice the depth, so full and empty stay apart.
    function int unsigned fill_level();
      return (tail + 2 * RING_DEPTH - head) % (2 * RING_DEPTH);
    endfunction

    function trace_result_t shape_result(logic [1:0] kind, trace_record_t rec, logic last);
      trace_result_t r;
      r.kind          = kind;
      r.rec_code      = rec.code;
      r.rec_category  = rec.category;
      r.rec_severity  = rec.severity;
      r.rec_detail    = rec.detail;
      r.rec_tick      = rec.tick;
      r.last          = last;
      r.occupancy     = 5'(fill_level());
      r.dropped_count = drops;
      r.total_count   = pushes;
      r.fault_count   = faults;
      return r;
    endfunction

    function void note_command(trace_cmd_t c);
      trace_record_t rec;
      logic [1:0]    kind;
      int unsigned   take;
      if (c.cmd != CMD_READ) begin
        rec.code     = c.code;
        rec.category = c.cmd;
        rec.severity = (c.cmd == CMD_PUSH_FAULT) ? c.severity : 8'h00;
        rec.detail   = c.detail;
        rec.tick     = c.tick;
        if (fill_level() >= RING_DEPTH) begin
          drops++;
          kind = KIND_DROPPED;
        end else begin
          ring[tail % RING_DEPTH] = rec;
          tail = (tail + 1) % (2 * RING_DEPTH);
          kind = KIND_STORED;
        end
        pushes++;
        if (c.cmd == CMD_PUSH_FAULT) faults++;
        expected_q.push_back(shape_result(kind, '0, 1'b1));
      end else begin
        take = (c.max_read > MAX_DRAIN) ? MAX_DRAIN : c.max_read;
        if (fill_level() < take) take = fill_level();
        if (take == 0) begin
          expected_q.push_back(shape_result(KIND_NONE, '0, 1'b1));
        end else begin
          for (int unsigned n = 0; n < take; n++) begin
            rec  = ring[head % RING_DEPTH];
            head = (head + 1) % (2 * RING_DEPTH);
            expected_q.push_back(shape_result(KIND_RETURNED, rec, (n + 1 == take)));
          end
        end
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      end
    endfunction

    function void check_result(trace_result_t got);
      trace_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $error("unexpected result: kind %0d, occupancy %0d", got.kind, got.occupancy);
      end else begin
        want = expected_q.pop_front();
        compare_field("kind",          want.kind,          got.kind);
        compare_field("rec_code",      want.rec_code,      got.rec_code);
        compare_field("rec_category",  want.rec_category,  got.rec_category);
        compare_field("rec_severity",  want.rec_severity,  got.rec_severity);
        compare_field("rec_detail",    want.rec_detail,    got.rec_detail);
        compare_field("rec_tick",      want.rec_tick,      got.rec_tick);
        compare_field("last",          want.last,          got.last);
        compare_field("occupancy",     want.occupancy,     got.occupancy);
        compare_field("dropped_count", want.dropped_count, got.dropped_count);
        compare_field("total_count",   want.total_count,   got.total_count);
        compare_field("fault_count",   want.fault_count,   got.fault_count);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  etrb_req_if req_if ();
  etrb_rsp_if rsp_if ();

  event_trace_ring_buffer_core #(
    .DEPTH (RING_DEPTH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  trace_scoreboard sb = new();

  // Bumped by the stimulus to ask the sink for one long hold-off.
  int unsigned hold_requests = 0;

  // Cycles since the last transfer on either channel.
  int unsigned idle_cycles = 0;

  // 4 ns clock: low half, then high half.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic trace_cmd_t command_item(logic [1:0] cmd, logic [15:0] code,
                                               logic [7:0] severity, logic [31:0] detail,
                                               logic [31:0] tick, logic [4:0] max_read);
    trace_cmd_t c;
    c.cmd      = cmd;
    c.code     = code;
    c.severity = severity;
    c.detail   = detail;
    c.tick     = tick;
    c.max_read = max_read;
    return c;
  endfunction

  // Draw a command: a read with the given percentage, else one of the three pushes.
  // Drain sizes stay mostly in range; now and then they overshoot to test saturation.
  function automatic trace_cmd_t random_command(int unsigned read_pct);
    trace_cmd_t c;
    if ($urandom_range(0, 99) < read_pct) c.cmd = CMD_READ;
    else                                  c.cmd = 2'($urandom_range(0, 2));
    c.code     = 16'($urandom);
    c.severity = 8'($urandom);
    c.detail   = $urandom;
    c.tick     = $urandom;
    c.max_read = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, MAX_DRAIN))
                                              : 5'($urandom_range(MAX_DRAIN + 1, 31));
    return c;
  endfunction

  // Offer one command at the falling edge and hold it until the transfer completes.
  // Valid is not lowered here, so back-to-back commands keep it high.
  task automatic offer_command(trace_cmd_t c);
    @(negedge clk_i);
    req_if.valid    <= 1'b1;
    req_if.cmd      <= c.cmd;
    req_if.code     <= c.code;
    req_if.severity <= c.severity;
    req_if.detail   <= c.detail;
    req_if.tick     <= c.tick;
    req_if.max_read <= c.max_read;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sb.note_command(c);
  endtask

  // Drop valid for a number of cycles; scramble the payload so idle cycles carry noise.
  task automatic pause_sender(int unsigned cycles);
    @(negedge clk_i);
    req_if.valid    <= 1'b0;
    req_if.cmd      <= 2'($urandom);
    req_if.code     <= 16'($urandom);
    req_if.severity <= 8'($urandom);
    req_if.detail   <= $urandom;
    req_if.tick     <= $urandom;
    req_if.max_read <= 5'($urandom);
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Result sink: random stall patterns, each held for a random stretch, plus the long
  // hold-off on request, counted down here.
  initial begin : result_sink
    int unsigned mode;
    int unsigned mode_left;
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned holds_seen;
    int unsigned phase;
    logic        next_ready;
    mode         = 0;
    mode_left    = 0;
    stall_left   = 0;
    hold_left    = 0;
    holds_seen   = 0;
    phase        = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = HOLD_OFF_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 60);
      end
      mode_left--;
      phase++;
      if (hold_left != 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else begin
        case (mode)
          0: begin
            next_ready = 1'b1;
          end
          1: begin
            next_ready = 1'($urandom_range(0, 1));
          end
          2: begin
            next_ready = (phase % 5) != 0;
          end
          default: begin
            if (stall_left != 0) begin
              stall_left--;
              next_ready = 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
              stall_left = $urandom_range(1, 8);
              next_ready = 1'b0;
            end else begin
              next_ready = 1'b1;
            end
          end
        endcase
      end
      rsp_if.ready <= next_ready;
    end
  end

  // Check every result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    trace_result_t got;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got.kind          = rsp_if.kind;
      got.rec_code      = rsp_if.rec_code;
      got.rec_category  = rsp_if.rec_category;
      got.rec_severity  = rsp_if.rec_severity;
      got.rec_detail    = rsp_if.rec_detail;
      got.rec_tick      = rsp_if.rec_tick;
      got.last          = rsp_if.last;
      got.occupancy     = rsp_if.occupancy;
      got.dropped_count = rsp_if.dropped_count;
      got.total_count   = rsp_if.total_count;
      got.fault_count   = rsp_if.fault_count;
      sb.check_result(got);
    end
  end

  // Watchdog: give up once neither channel has moved a transfer for too long.
  always @(posedge clk_i) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    trace_cmd_t  directed_q [$];
    int unsigned sent;
    int unsigned burst_left;
    int unsigned read_pct;
    int unsigned seg_left;

    sent       = 0;
    burst_left = 0;
    read_pct   = 30;
    seg_left   = 0;

    req_if.valid    = 1'b0;
    req_if.cmd      = CMD_PUSH_EVENT;
    req_if.code     = '0;
    req_if.severity = '0;
    req_if.detail   = '0;
    req_if.tick     = '0;
    req_if.max_read = '0;

    // Hold reset, then release it away from the rising edge.
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: empty read, field extremes on all three pushes (severity must be
    // cleared on non-fault pushes), zero-size read, oversized read, a fill beyond
    // capacity so that one push is dropped, then a full drain.
    directed_q.push_back(command_item(CMD_READ, '0, '0, '0, '0, 5'd5));
    directed_q.push_back(command_item(CMD_PUSH_EVENT, '1, '1, '1, '1, 5'd31));
    directed_q.push_back(command_item(CMD_PUSH_FAULT, '0, '1, '0, '0, 5'd0));
    directed_q.push_back(command_item(CMD_PUSH_TRACE, 16'hA5A5, 8'h5A, 32'h5555_AAAA,
                                      32'hAAAA_5555, 5'd16));
    directed_q.push_back(command_item(CMD_READ, '1, '1, '1, '1, 5'd0));
    directed_q.push_back(command_item(CMD_READ, '0, '0, '0, '0, 5'd31));
    for (int unsigned i = 0; i <= RING_DEPTH; i++) begin
      directed_q.push_back(command_item(2'(i % 3), 16'($urandom), 8'($urandom), $urandom,
                                        $urandom, 5'($urandom)));
    end
    directed_q.push_back(command_item(CMD_READ, '0, '0, '0, '0, 5'(MAX_DRAIN)));
    foreach (directed_q[i]) offer_command(directed_q[i]);

    // Random part: segments with different read mixes, so the ring swings between full
    // (drops) and empty (no-record reads); bursts of transfers split by random gaps.
    while (sent < RANDOM_ITEMS) begin
      if (sent == PRESSURE_AT) begin
        // Stall the sink for a long stretch and keep pushing: the ring, the queue and
        // the result stage fill up and the input must push back.
        hold_requests++;
        repeat (PRESSURE_ITEMS) offer_command(random_command(0));
        sent += PRESSURE_ITEMS;
      end
      if (seg_left == 0) begin
        case ($urandom_range(0, 2))
          0:       read_pct = 10;
          1:       read_pct = 30;
          default: read_pct = 55;
        endcase
        seg_left = $urandom_range(20, 60);
      end
      seg_left--;
      offer_command(random_command(read_pct));
      sent++;
      if (burst_left == 0) begin
        // Occasionally run a long burst with no gap at all.
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 12);
        pause_sender($urandom_range(1, 12));
      end else begin
        burst_left--;
      end
    end

    // Drop valid, let every expected result arrive, then allow for a late stray one.
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
